// File: src/ssd_pkg.sv
// shared types and constants for the substring deleter
package ssd_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int CHAR_W    = 8;
    localparam int PATTERN_W = 64;
    localparam int PLEN_W    = 4;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN     = 1'b0,
        REG_PATTERN_LEN = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DELETE,
        S_FLUSH,
        S_END
    } state_t;

    typedef struct packed {
        logic               kind;
        logic [CHAR_W-1:0]  out_char;
        logic [COUNT_W-1:0] removed_count;
        logic               run_end;
    } res_t;

    typedef struct packed {
        logic append;
        logic shift;
    } win_cmd_t;

    typedef struct packed {
        logic ok;
        logic complete;
    } match_t;

endpackage

// File: src/ssd_window.sv
// undecided byte window: shift register with append at the fill point
module ssd_window #(
    parameter int MAX_PATTERN = ssd_pkg::MAX_PATTERN_DEF,
    parameter int LEN_BITS    = $clog2(MAX_PATTERN + 1)
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  ssd_pkg::win_cmd_t                       cmd,
    input  logic [ssd_pkg::CHAR_W-1:0]              wr_char,
    output logic [MAX_PATTERN-1:0][ssd_pkg::CHAR_W-1:0] win_bytes,
    output logic [LEN_BITS-1:0]                     win_fill
);
    import ssd_pkg::*;

    localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0][CHAR_W-1:0] buf_reg;
    logic [LEN_BITS-1:0]                fill_reg;

    // payload entries, no reset
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            buf_reg[fill_reg[IDX_BITS-1:0]] <= wr_char;
        end else if (cmd.shift) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.append) begin
            fill_reg <= fill_reg + LEN_BITS'(1);
        end else if (cmd.shift && fill_reg != '0) begin
            fill_reg <= fill_reg - LEN_BITS'(1);
        end
    end

    assign win_bytes = buf_reg;
    assign win_fill  = fill_reg;

endmodule

// File: src/ssd_match.sv
// shared window compare unit, all buffered bytes up to the pattern length against the pattern at once
module ssd_match #(
    parameter int MAX_PATTERN = ssd_pkg::MAX_PATTERN_DEF,
    parameter int LEN_BITS    = $clog2(MAX_PATTERN + 1)
) (
    input  logic [MAX_PATTERN-1:0][ssd_pkg::CHAR_W-1:0] win_bytes,
    input  logic [LEN_BITS-1:0]                     win_fill,
    input  logic [ssd_pkg::PATTERN_W-1:0]           pattern,
    input  logic [LEN_BITS-1:0]                     used_len,
    output ssd_pkg::match_t                         result
);
    import ssd_pkg::*;

    logic ok;

    always_comb begin
        ok = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (LEN_BITS'(k) < win_fill && LEN_BITS'(k) < used_len &&
                win_bytes[k] != pattern[k*CHAR_W +: CHAR_W]) begin
                ok = 1'b0;
            end
        end
        result.ok       = ok;
        result.complete = (win_fill >= used_len);
    end

endmodule

// File: src/stream_substring_deleter.sv
// top level of the streaming substring deleter: sequencer, config and result registers
//
// channel | direction | handshake        | payload
// s_      | in        | s_valid/s_ready  | s_in_char, s_is_final
// m_      | out       | m_valid/m_ready  | m_kind, m_out_char, m_removed_count, m_run_end
// cfg_    | in        | cfg_valid/ready  | cfg_index, cfg_data
//
// each byte is accepted in idle, scanned and wrapped up in the end state; kept bytes are emitted
// when released by a failed rescan, a skip or the flush, a deletion shifts the matched bytes out
// in the delete state, and a final string's flush ends with the end transaction; the sequencer
// steps the window one byte per cycle through the shared compare unit while the result path has room
// s_ready is high only in idle; a full result path stalls the sequencer in place
// aresetn is synchronous: clears the window, tally, skip flag and result registers
// pattern resets to zero and pattern_len to one; configuration is always accepted
module stream_substring_deleter #(
    parameter int MAX_PATTERN = ssd_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = ssd_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input transactions
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ssd_pkg::CHAR_W-1:0]        s_in_char,
    input  logic                              s_is_final,
    // result transactions
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic [ssd_pkg::CHAR_W-1:0]        m_out_char,
    output logic [ssd_pkg::COUNT_W-1:0]       m_removed_count,
    output logic                              m_run_end,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssd_pkg::PATTERN_W-1:0]     cfg_data
);
    import ssd_pkg::*;

    localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

    // configuration registers
    logic [PATTERN_W-1:0] pattern_reg;
    logic [PLEN_W-1:0]    plen_reg;
    logic [LEN_BITS-1:0]  used_len;

    // sequencer state
    state_t               state_reg, state_next;
    logic                 skip_reg, skip_next;
    logic                 fin_reg, fin_next;
    logic [COUNT_BITS-1:0] tally_reg, tally_next;
    logic [LEN_BITS-1:0]  del_cnt_reg, del_cnt_next;

    // held result (run_end not yet known) and output register
    logic                 pend_valid_reg;
    res_t                 pend_reg;
    logic                 out_valid_reg;
    res_t                 out_reg;

    // control between sequencer, window and compare unit
    win_cmd_t                        win_cmd;
    logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_bytes;
    logic [LEN_BITS-1:0]             win_fill;
    match_t                          match;

    logic                 produce;
    logic                 finish;
    res_t                 res_new;
    logic                 out_free;
    logic                 can_produce;

    // configuration port, no back-pressure
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= PLEN_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_PATTERN:     pattern_reg <= cfg_data;
                REG_PATTERN_LEN: plen_reg    <= cfg_data[PLEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // lengths above the window depth act as the full depth
    assign used_len = (plen_reg > PLEN_W'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN)
                                                        : LEN_BITS'(plen_reg);

    ssd_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_BITS    (LEN_BITS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (win_cmd),
        .wr_char   (s_in_char),
        .win_bytes (win_bytes),
        .win_fill  (win_fill)
    );

    ssd_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_BITS    (LEN_BITS)
    ) u_match (
        .win_bytes (win_bytes),
        .win_fill  (win_fill),
        .pattern   (pattern_reg),
        .used_len  (used_len),
        .result    (match)
    );

    // a new result can be taken when none is held or the held one can move on
    assign out_free    = !out_valid_reg || m_ready;
    assign can_produce = !pend_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            skip_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            tally_reg   <= '0;
            del_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            skip_reg    <= skip_next;
            fin_reg     <= fin_next;
            tally_reg   <= tally_next;
            del_cnt_reg <= del_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        skip_next    = skip_reg;
        fin_next     = fin_reg;
        tally_next   = tally_reg;
        del_cnt_next = del_cnt_reg;
        win_cmd      = '0;
        produce      = 1'b0;
        finish       = 1'b0;
        s_ready      = 1'b0;
        // default result: kept byte from the head of the window
        res_new               = '0;
        res_new.kind          = KIND_CHAR;
        res_new.out_char      = win_bytes[0];

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    win_cmd.append = 1'b1;
                    fin_next       = s_is_final;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN: begin
                if (win_fill == '0) begin
                    state_next = fin_reg ? S_FLUSH : S_END;
                end else if (skip_reg || used_len == '0) begin
                    // byte after a deletion, or no pattern: kept untested
                    if (can_produce) begin
                        produce       = 1'b1;
                        win_cmd.shift = 1'b1;
                        skip_next     = 1'b0;
                    end
                end else if (match.ok && match.complete) begin
                    del_cnt_next = used_len;
                    skip_next    = 1'b1;
                    if (tally_reg != '1) begin
                        tally_next = tally_reg + COUNT_BITS'(1);
                    end
                    state_next = S_DELETE;
                end else if (match.ok) begin
                    // partial match: flush if the string is final, else wait for more bytes
                    state_next = fin_reg ? S_FLUSH : S_END;
                end else if (can_produce) begin
                    // mismatch: release the head byte and rescan the rest
                    produce       = 1'b1;
                    win_cmd.shift = 1'b1;
                end
            end

            S_DELETE: begin
                win_cmd.shift = 1'b1;
                del_cnt_next  = del_cnt_reg - LEN_BITS'(1);
                if (del_cnt_reg == LEN_BITS'(1)) begin
                    state_next = S_SCAN;
                end
            end

            S_FLUSH: begin
                if (can_produce) begin
                    produce = 1'b1;
                    if (win_fill != '0) begin
                        win_cmd.shift = 1'b1;
                    end else begin
                        res_new.kind          = KIND_END;
                        res_new.out_char      = '0;
                        res_new.removed_count = COUNT_W'(tally_reg);
                        tally_next            = '0;
                        skip_next             = 1'b0;
                        fin_next              = 1'b0;
                        state_next            = S_END;
                    end
                end
            end

            S_END: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // held result and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (produce) begin
                pend_valid_reg <= 1'b1;
            end else if (finish) begin
                pend_valid_reg <= 1'b0;
            end
            if ((produce && pend_valid_reg) || finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            pend_reg <= res_new;
        end
        if (produce && pend_valid_reg) begin
            out_reg         <= pend_reg;
            out_reg.run_end <= 1'b0;
        end else if (finish) begin
            out_reg         <= pend_reg;
            out_reg.run_end <= 1'b1;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_out_char      = out_reg.out_char;
    assign m_removed_count = out_reg.removed_count;
    assign m_run_end       = out_reg.run_end;

`ifndef NO_ASSERTIONS
    // a new transaction only starts once the previous one's results are all released
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("input accepted with a held result");

    // the window never holds more than MAX_PATTERN bytes
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        win_fill <= LEN_BITS'(MAX_PATTERN))
        else $error("window overfilled");

    // the end-of-string result is always the last of its transaction
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_END) |-> m_run_end)
        else $error("end result not marked last");

    // emitting the end result clears the tally for the next string
    a_tally_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && res_new.kind == KIND_END) |=> (tally_reg == '0 && !skip_reg))
        else $error("tally not cleared at end of string");
`endif

endmodule
